@@ hw/rtl/lcdf_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdf_pkg
// shared codes, constants and request descriptor for the lcd write formatter
// ----------------------------------------------------------------------------
package lcdf_pkg;

    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_CMD    = 3'd1;
    localparam logic [2:0] KIND_CURSOR = 3'd2;
    localparam logic [2:0] KIND_NUMBER = 3'd3;
    localparam logic [2:0] KIND_INIT   = 3'd4;

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] DDRAM_BASE       = 8'h80;
    localparam logic [7:0] ROW1_OFFSET      = 8'h40;
    localparam logic [7:0] ASCII_ZERO       = 8'h30;
    localparam logic [7:0] ASCII_MINUS      = 8'h2D;

    localparam int MAG_W       = 32;
    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int STEP_W      = $clog2(MAG_W);
    localparam int DCNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int INIT_LEN    = 3;
    localparam int INIT_W      = $clog2(INIT_LEN);

    typedef enum logic [1:0] {
        OP_SINGLE = 2'd0,
        OP_INIT   = 2'd1,
        OP_NUMBER = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             is_data;
        logic [7:0]       byte_value;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } desc_t;

    function automatic logic [7:0] init_byte(input logic [INIT_W-1:0] step);
        logic [7:0] b;
        case (step)
            INIT_W'(0): b = CMD_FUNCTION_SET;
            INIT_W'(1): b = CMD_DISPLAY_ON;
            default:    b = CMD_CLEAR;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/lcdf_front.sv @@
// ----------------------------------------------------------------------------
// lcdf_front
// takes requests, classifies them and converts integers to bcd
// ----------------------------------------------------------------------------
module lcdf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          kind,
    input  logic [7:0]          byte_value,
    input  logic                row,
    input  logic [5:0]          column,
    input  logic signed [31:0]  number,
    input  logic                q_full,
    output logic                busy,
    output logic                push,
    output lcdf_pkg::desc_t     push_desc
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_DONE = 3'b100
    } fstate_t;

    fstate_t                          state_reg, state_next;
    logic [lcdf_pkg::MAG_W-1:0]       mag_reg, mag_next;
    logic [lcdf_pkg::BCD_W-1:0]       bcd_reg, bcd_next;
    logic                             neg_reg, neg_next;
    logic [lcdf_pkg::STEP_W-1:0]      step_reg, step_next;

    logic                             accept;
    logic [lcdf_pkg::MAG_W-1:0]       mag_in;
    logic [lcdf_pkg::BCD_W-1:0]       bcd_adj;
    logic [7:0]                       cursor_byte;
    logic                             direct_kind;

    assign busy   = (state_reg != F_IDLE) || q_full;
    assign accept = start && !busy;
    assign mag_in = number[31] ? (~number + 32'd1) : number;
    assign cursor_byte = lcdf_pkg::DDRAM_BASE + (row ? lcdf_pkg::ROW1_OFFSET : 8'd0)
                       + {2'b00, column};
    assign direct_kind = (kind == lcdf_pkg::KIND_DATA) || (kind == lcdf_pkg::KIND_CMD)
                      || (kind == lcdf_pkg::KIND_CURSOR) || (kind == lcdf_pkg::KIND_INIT);

    // add-3 on each digit ahead of the shift
    always_comb
    begin
        logic [3:0] d;
        bcd_adj = bcd_reg;
        for (int i = 0; i < lcdf_pkg::NUM_DIGITS; i++)
        begin
            d = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        push       = 1'b0;
        push_desc.op         = lcdf_pkg::OP_SINGLE;
        push_desc.is_data    = 1'b0;
        push_desc.byte_value = byte_value;
        push_desc.neg        = neg_reg;
        push_desc.bcd        = bcd_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        lcdf_pkg::KIND_DATA:
                        begin
                            push_desc.is_data = 1'b1;
                        end
                        lcdf_pkg::KIND_CURSOR:
                        begin
                            push_desc.byte_value = cursor_byte;
                        end
                        lcdf_pkg::KIND_INIT:
                        begin
                            push_desc.op = lcdf_pkg::OP_INIT;
                        end
                        lcdf_pkg::KIND_NUMBER:
                        begin
                            mag_next   = mag_in;
                            bcd_next   = '0;
                            neg_next   = number[31];
                            step_next  = '0;
                            state_next = F_CONV;
                        end
                        default:
                        begin
                            push_desc.is_data = 1'b0;
                        end
                    endcase
                    push = direct_kind;
                end
            end
            F_CONV:
            begin
                bcd_next  = {bcd_adj[lcdf_pkg::BCD_W-2:0], mag_reg[lcdf_pkg::MAG_W-1]};
                mag_next  = {mag_reg[lcdf_pkg::MAG_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == lcdf_pkg::STEP_W'(lcdf_pkg::MAG_W - 1))
                begin
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                push_desc.op      = lcdf_pkg::OP_NUMBER;
                push_desc.is_data = 1'b1;
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
    end

endmodule

@@ hw/rtl/lcdf_queue.sv @@
// ----------------------------------------------------------------------------
// lcdf_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module lcdf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lcdf_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output lcdf_pkg::desc_t head
);

    lcdf_pkg::desc_t                 mem [lcdf_pkg::QUEUE_DEPTH];
    logic [lcdf_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lcdf_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [lcdf_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full  = (count_reg == lcdf_pkg::QCNT_W'(lcdf_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == lcdf_pkg::QPTR_W'(lcdf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lcdf_pkg::QPTR_W'(lcdf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

@@ hw/rtl/lcdf_back.sv @@
// ----------------------------------------------------------------------------
// lcdf_back
// serializes queued requests into single bus writes
// ----------------------------------------------------------------------------
module lcdf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  lcdf_pkg::desc_t head,
    output logic            pop,
    output logic            strobe,
    output logic            is_data,
    output logic [7:0]      bus_byte,
    output logic            last
);

    typedef enum logic [5:0] {
        B_IDLE   = 6'b000001,
        B_SINGLE = 6'b000010,
        B_INIT   = 6'b000100,
        B_MINUS  = 6'b001000,
        B_SKIP   = 6'b010000,
        B_DIGITS = 6'b100000
    } bstate_t;

    bstate_t                        state_reg, state_next;
    logic                           kind_data_reg, kind_data_next;
    logic [7:0]                     byte_reg, byte_next;
    logic [lcdf_pkg::BCD_W-1:0]     bcd_reg, bcd_next;
    logic [lcdf_pkg::DCNT_W-1:0]    cnt_reg, cnt_next;
    logic [lcdf_pkg::INIT_W-1:0]    init_reg, init_next;
    logic                           strobe_reg, strobe_next;
    logic                           is_data_reg, is_data_next;
    logic [7:0]                     bus_byte_reg, bus_byte_next;
    logic                           last_reg, last_next;

    logic [3:0]                     top_digit;
    logic                           final_digit;
    logic                           final_init;

    assign pop         = (state_reg == B_IDLE) && !q_empty;
    assign top_digit   = bcd_reg[lcdf_pkg::BCD_W-1 -: 4];
    assign final_digit = (cnt_reg == lcdf_pkg::DCNT_W'(1));
    assign final_init  = (init_reg == lcdf_pkg::INIT_W'(lcdf_pkg::INIT_LEN - 1));

    assign strobe   = strobe_reg;
    assign is_data  = is_data_reg;
    assign bus_byte = bus_byte_reg;
    assign last     = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_data_next = kind_data_reg;
        byte_next      = byte_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        init_next      = init_reg;
        strobe_next    = 1'b0;
        is_data_next   = is_data_reg;
        bus_byte_next  = bus_byte_reg;
        last_next      = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    kind_data_next = head.is_data;
                    byte_next      = head.byte_value;
                    bcd_next       = head.bcd;
                    cnt_next       = lcdf_pkg::DCNT_W'(lcdf_pkg::NUM_DIGITS);
                    init_next      = '0;
                    case (head.op)
                        lcdf_pkg::OP_SINGLE: state_next = B_SINGLE;
                        lcdf_pkg::OP_INIT:   state_next = B_INIT;
                        lcdf_pkg::OP_NUMBER: state_next = head.neg ? B_MINUS : B_SKIP;
                        default:             state_next = B_IDLE;
                    endcase
                end
            end
            B_SINGLE:
            begin
                strobe_next   = 1'b1;
                is_data_next  = kind_data_reg;
                bus_byte_next = byte_reg;
                last_next     = 1'b1;
                state_next    = B_IDLE;
            end
            B_INIT:
            begin
                strobe_next   = 1'b1;
                is_data_next  = 1'b0;
                bus_byte_next = lcdf_pkg::init_byte(init_reg);
                last_next     = final_init;
                init_next     = init_reg + 1'b1;
                if (final_init)
                begin
                    state_next = B_IDLE;
                end
            end
            B_MINUS:
            begin
                strobe_next   = 1'b1;
                is_data_next  = 1'b1;
                bus_byte_next = lcdf_pkg::ASCII_MINUS;
                state_next    = B_SKIP;
            end
            // drop leading zero digits, keep at least one
            B_SKIP:
            begin
                if ((top_digit == 4'd0) && !final_digit)
                begin
                    bcd_next = {bcd_reg[lcdf_pkg::BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = B_DIGITS;
                end
            end
            B_DIGITS:
            begin
                strobe_next   = 1'b1;
                is_data_next  = 1'b1;
                bus_byte_next = lcdf_pkg::ASCII_ZERO + {4'd0, top_digit};
                last_next     = final_digit;
                bcd_next      = {bcd_reg[lcdf_pkg::BCD_W-5:0], 4'd0};
                cnt_next      = cnt_reg - 1'b1;
                if (final_digit)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_data_reg <= kind_data_next;
        byte_reg      <= byte_next;
        bcd_reg       <= bcd_next;
        cnt_reg       <= cnt_next;
        init_reg      <= init_next;
        is_data_reg   <= is_data_next;
        bus_byte_reg  <= bus_byte_next;
    end

endmodule

@@ hw/rtl/char_lcd_write_formatter.sv @@
// ----------------------------------------------------------------------------
// char_lcd_write_formatter
// turns display requests into tagged 8-bit character lcd bus writes
//
//   channel   handshake        payload
//   request   start / busy     kind, byte_value, row, column, number
//   write     strobe           is_data, bus_byte, last
//
// integer requests: busy after acceptance through a 32-step bcd conversion
// and a hand-off state; other kinds are pushed to the queue as they are accepted.
// the back fetches each request in its idle state, then makes its writes; an
// integer also passes a state that drops leading zeros between sign and digits.
// busy also rises while the two-entry queue is full; writes cannot be held off.
// reset clears all control state; nothing needs a clearing pass.
// ----------------------------------------------------------------------------
module char_lcd_write_formatter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic [7:0]         byte_value,
    input  logic               row,
    input  logic [5:0]         column,
    input  logic signed [31:0] number,
    output logic               strobe,
    output logic               is_data,
    output logic [7:0]         bus_byte,
    output logic               last
);

    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    lcdf_pkg::desc_t push_desc;
    lcdf_pkg::desc_t head;

    lcdf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .byte_value (byte_value),
        .row        (row),
        .column     (column),
        .number     (number),
        .q_full     (q_full),
        .busy       (busy),
        .push       (push),
        .push_desc  (push_desc)
    );

    lcdf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    lcdf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .strobe   (strobe),
        .is_data  (is_data),
        .bus_byte (bus_byte),
        .last     (last)
    );

endmodule

@@ hw/rtl/lcdf_checker.sv @@
// ----------------------------------------------------------------------------
// lcdf_checker
// port-level checks on the lcd write formatter
// ----------------------------------------------------------------------------
module lcdf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [2:0]         kind,
    input logic               strobe,
    input logic               is_data,
    input logic [7:0]         bus_byte,
    input logic               last
);

    // last only marks a real write
    a_last_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    // integer conversion keeps the front busy
    a_number_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == lcdf_pkg::KIND_NUMBER)) |=> busy)
        else $error("not busy during conversion");

    // data writes that are not last come only from integer printing
    a_data_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && is_data && !last) |->
            ((bus_byte == lcdf_pkg::ASCII_MINUS)
             || ((bus_byte >= lcdf_pkg::ASCII_ZERO) && (bus_byte <= 8'h39))))
        else $error("unexpected data byte in run");

    // command writes that are not last come only from init
    a_cmd_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !is_data && !last) |->
            ((bus_byte == lcdf_pkg::CMD_FUNCTION_SET)
             || (bus_byte == lcdf_pkg::CMD_DISPLAY_ON)))
        else $error("unexpected command byte in run");

endmodule

bind char_lcd_write_formatter lcdf_checker u_lcdf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .kind     (kind),
    .strobe   (strobe),
    .is_data  (is_data),
    .bus_byte (bus_byte),
    .last     (last)
);

@@ tb/lcd_write_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_write_checker
// watches the request and write channels of the lcd write formatter, predicts
// the bus writes for every accepted request and compares each strobed write
// ----------------------------------------------------------------------------
module lcd_write_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         kind,
    input  logic [7:0]         byte_value,
    input  logic               row,
    input  logic [5:0]         column,
    input  logic signed [31:0] number,
    input  logic               strobe,
    input  logic               is_data,
    input  logic [7:0]         bus_byte,
    input  logic               last,
    output int                 fail_count,
    output int                 pending,
    output int                 writes_seen
);

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } lcd_write_t;

    lcd_write_t expected_writes[$];

    initial
    begin
        fail_count  = 0;
        pending     = 0;
        writes_seen = 0;
    end

    function automatic void predict_writes(input logic [2:0] k, input logic [7:0] b,
                                           input logic r, input logic [5:0] c,
                                           input logic [31:0] n);
        lcd_write_t w[$];
        logic [7:0] digits[$];
        logic [31:0] mag;
        case (k)
            lcdf_pkg::KIND_DATA:   w.push_back('{1'b1, b, 1'b0});
            lcdf_pkg::KIND_CMD:    w.push_back('{1'b0, b, 1'b0});
            lcdf_pkg::KIND_CURSOR:
                w.push_back('{1'b0, lcdf_pkg::DDRAM_BASE
                                    + (r ? lcdf_pkg::ROW1_OFFSET : 8'h00)
                                    + {2'b00, c}, 1'b0});
            lcdf_pkg::KIND_NUMBER:
            begin
                mag = n;
                if (n[31])
                begin
                    w.push_back('{1'b1, lcdf_pkg::ASCII_MINUS, 1'b0});
                    mag = ~n + 32'd1;
                end
                do
                begin
                    digits.push_front(lcdf_pkg::ASCII_ZERO + 8'(mag % 32'd10));
                    mag = mag / 32'd10;
                end
                while (mag != 32'd0);
                foreach (digits[i])
                    w.push_back('{1'b1, digits[i], 1'b0});
            end
            lcdf_pkg::KIND_INIT:
            begin
                w.push_back('{1'b0, lcdf_pkg::CMD_FUNCTION_SET, 1'b0});
                w.push_back('{1'b0, lcdf_pkg::CMD_DISPLAY_ON, 1'b0});
                w.push_back('{1'b0, lcdf_pkg::CMD_CLEAR, 1'b0});
            end
            default: ;
        endcase
        if (w.size() > 0)
            w[w.size() - 1].last = 1'b1;
        foreach (w[i])
            expected_writes.push_back(w[i]);
    endfunction

    always @(posedge clk)
    begin
        lcd_write_t exp_w;
        if (rst_n)
        begin
            if (strobe)
            begin
                writes_seen++;
                if (expected_writes.size() == 0)
                begin
                    $display("%0t unexpected write: expected none actual %0b %h %0b",
                             $time, is_data, bus_byte, last);
                    fail_count++;
                end
                else
                begin
                    exp_w = expected_writes.pop_front();
                    if (is_data !== exp_w.is_data)
                    begin
                        $display("%0t is_data mismatch: expected %0b actual %0b",
                                 $time, exp_w.is_data, is_data);
                        fail_count++;
                    end
                    if (bus_byte !== exp_w.bus_byte)
                    begin
                        $display("%0t bus_byte mismatch: expected %h actual %h",
                                 $time, exp_w.bus_byte, bus_byte);
                        fail_count++;
                    end
                    if (last !== exp_w.last)
                    begin
                        $display("%0t last mismatch: expected %0b actual %0b",
                                 $time, exp_w.last, last);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                predict_writes(kind, byte_value, row, column, number);
            pending = expected_writes.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// directed and random requests for the lcd write formatter, sent in bursts
// with random gaps; the checker beside the block compares every bus write
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
    localparam int RANDOM_REQUESTS = 180;
    localparam int DRAIN_CYCLES    = 80;
    localparam int CYCLE_LIMIT     = 300000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         kind;
    logic [7:0]         byte_value;
    logic               row;
    logic [5:0]         column;
    logic signed [31:0] number;
    logic               strobe;
    logic               is_data;
    logic [7:0]         bus_byte;
    logic               last;

    int fail_count;
    int pending;
    int writes_seen;
    int cycle_count;
    int burst_left;
    int kind_count[8];
    int negative_count;

    char_lcd_write_formatter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .byte_value (byte_value),
        .row        (row),
        .column     (column),
        .number     (number),
        .strobe     (strobe),
        .is_data    (is_data),
        .bus_byte   (bus_byte),
        .last       (last)
    );

    lcd_write_checker write_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .byte_value  (byte_value),
        .row         (row),
        .column      (column),
        .number      (number),
        .strobe      (strobe),
        .is_data     (is_data),
        .bus_byte    (bus_byte),
        .last        (last),
        .fail_count  (fail_count),
        .pending     (pending),
        .writes_seen (writes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("Regression FAIL");
        $finish;
    end

    task automatic issue_request(input logic [2:0] k, input logic [7:0] b, input logic r,
                                 input logic [5:0] c, input logic [31:0] n);
        start      <= 1'b1;
        kind       <= k;
        byte_value <= b;
        row        <= r;
        column     <= c;
        number     <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        kind_count[k]++;
        if (k == lcdf_pkg::KIND_NUMBER && n[31])
            negative_count++;
    endtask

    // bursts of back-to-back requests, then a gap of random length
    task automatic pace_sender();
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       gap = $urandom_range(1, 50);
                default: gap = $urandom_range(1, 6);
            endcase
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30)
                                                      : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue_with_noise(input logic [2:0] k, input logic [7:0] b,
                                    input logic r, input logic [5:0] c, input logic [31:0] n);
        issue_request(k, b, r, c, n);
        pace_sender();
    endtask

    function automatic logic [31:0] pick_number();
        int unsigned p;
        int unsigned e;
        logic [31:0] v;
        p = 1;
        case ($urandom_range(0, 6))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 40)) - 32'd20;
            2: v = 32'($urandom_range(1000000000, 2147483647));
            3: v = -32'($urandom_range(1000000000, 2147483647));
            4:
            begin
                e = $urandom_range(0, 9);
                repeat (e) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            5: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default:
            begin
                e = $urandom_range(1, 9);
                repeat (e) p = p * 10;
                v = $urandom % p;
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [2:0] pick_kind();
        int unsigned p;
        logic [2:0] k;
        p = $urandom_range(0, 99);
        if (p < 40)
            k = lcdf_pkg::KIND_NUMBER;
        else if (p < 55)
            k = lcdf_pkg::KIND_DATA;
        else if (p < 70)
            k = lcdf_pkg::KIND_CMD;
        else if (p < 85)
            k = lcdf_pkg::KIND_CURSOR;
        else if (p < 95)
            k = lcdf_pkg::KIND_INIT;
        else
            k = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        return k;
    endfunction

    initial
    begin
        int counted;
        int fail_total;
        int ignored_count;
        logic [2:0] k;
        start          = 1'b0;
        kind           = lcdf_pkg::KIND_DATA;
        byte_value     = 8'h00;
        row            = 1'b0;
        column         = 6'd0;
        number         = 32'sd0;
        rst_n          = 1'b0;
        burst_left     = 0;
        negative_count = 0;
        counted        = 0;
        ignored_count  = 0;
        foreach (kind_count[i])
            kind_count[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests
        issue_with_noise(lcdf_pkg::KIND_DATA, 8'h00, 1'b1, 6'd63, $urandom);
        issue_with_noise(lcdf_pkg::KIND_DATA, 8'hFF, 1'b0, 6'd0, $urandom);
        issue_with_noise(lcdf_pkg::KIND_CMD, 8'h00, 1'b1, 6'd63, $urandom);
        issue_with_noise(lcdf_pkg::KIND_CMD, 8'hFF, 1'b0, 6'd0, $urandom);
        issue_with_noise(lcdf_pkg::KIND_CURSOR, 8'hFF, 1'b0, 6'd0, $urandom);
        issue_with_noise(lcdf_pkg::KIND_CURSOR, 8'h00, 1'b1, 6'd63, $urandom);
        issue_with_noise(lcdf_pkg::KIND_CURSOR, 8'h5A, 1'b0, 6'd63, $urandom);
        issue_with_noise(lcdf_pkg::KIND_CURSOR, 8'hA5, 1'b1, 6'd0, $urandom);
        issue_with_noise(lcdf_pkg::KIND_INIT, 8'hFF, 1'b1, 6'd63, 32'hFFFF_FFFF);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'hFF, 1'b1, 6'd63, 32'd0);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, 32'd1);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, 32'hFFFF_FFFF);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, 32'd9);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, 32'd10);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, 32'h7FFF_FFFF);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, 32'h8000_0000);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, 32'h8000_0001);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, 32'd1000000000);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, -32'd1000000000);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, 32'd999999999);
        issue_with_noise(lcdf_pkg::KIND_NUMBER, 8'h00, 1'b0, 6'd0, 32'd4294967287);
        issue_with_noise(KIND_UNUSED_LO, 8'hFF, 1'b1, 6'd63, 32'hFFFF_FFFF);
        issue_with_noise(KIND_UNUSED_LO + 3'd1, 8'h00, 1'b0, 6'd0, 32'd0);
        issue_with_noise(KIND_UNUSED_HI, 8'h12, 1'b1, 6'd21, 32'd12345);
        issue_with_noise(lcdf_pkg::KIND_INIT, 8'h00, 1'b0, 6'd0, 32'd0);

        // random requests
        while (counted < RANDOM_REQUESTS)
        begin
            k = pick_kind();
            issue_with_noise(k, 8'($urandom), 1'($urandom), 6'($urandom), pick_number());
            if (k <= lcdf_pkg::KIND_INIT)
                counted++;
        end

        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        fail_total = fail_count;
        if (pending != 0)
        begin
            $display("%0t %0d writes still expected at end", $time, pending);
            fail_total++;
        end
        for (int i = KIND_UNUSED_LO; i <= KIND_UNUSED_HI; i++)
            ignored_count += kind_count[i];
        $display("covered %0d data, %0d command, %0d cursor, %0d init requests",
                 kind_count[lcdf_pkg::KIND_DATA], kind_count[lcdf_pkg::KIND_CMD],
                 kind_count[lcdf_pkg::KIND_CURSOR], kind_count[lcdf_pkg::KIND_INIT]);
        $display("%0d integer (%0d negative), %0d ignored, %0d writes, %0d failures",
                 kind_count[lcdf_pkg::KIND_NUMBER], negative_count, ignored_count,
                 writes_seen, fail_total);
        if (fail_total == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/lcdf_pkg.sv
hw/rtl/lcdf_front.sv
hw/rtl/lcdf_queue.sv
hw/rtl/lcdf_back.sv
hw/rtl/char_lcd_write_formatter.sv
hw/rtl/lcdf_checker.sv
tb/lcd_write_checker.sv
tb/testbench.sv
